/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the plasma colour index checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, skipped while reset is high
`define PPCI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ppci assertion failed");

// checked property, also checked during reset
`define PPCI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ppci assertion failed");

`endif

/* hdl/ppci_pkg.sv */
// ----------------------------------------------------------------------------
// ppci_pkg
// shared widths, constants and the quarter-wave sine table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppci_pkg;

  // squared distances are up to 33 bits, shifted left by 8 fraction bits squared
  localparam int D2_W   = 33;
  localparam int SQRT_W = 50;
  localparam int DIST_W = SQRT_W / 2;
  localparam int SQRT_LAT = SQRT_W / 2;
  localparam int SINE_LAT = 6;

  localparam int PMUL_W = 36;
  localparam logic [PMUL_W-1:0] PHASE_MUL_DIV4   = 36'd43748177609;
  localparam logic [PMUL_W-1:0] PHASE_MUL_DIV3P5 = 36'd49997917267;

  localparam int SINE_W = 17;

  // sin(k*pi/32) * 32768, k = 0..16
  localparam logic [15:0] QSINE [17] = '{
    16'd0,     16'd3212,  16'd6393,  16'd9512,  16'd12540, 16'd15447,
    16'd18205, 16'd20788, 16'd23170, 16'd25330, 16'd27246, 16'd28899,
    16'd30274, 16'd31357, 16'd32138, 16'd32610, 16'd32768
  };

endpackage

/* hdl/ppci_if.sv */
// ----------------------------------------------------------------------------
// ppci_if
// valid/ready channels for pixel requests and colour index results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ppci_in_if;
  logic        valid;
  logic        ready;
  logic [6:0]  pixel_x;
  logic [5:0]  pixel_y;
  logic [15:0] frame_time;

  modport source (output valid, output pixel_x, output pixel_y, output frame_time,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input frame_time,
                  output ready);
endinterface

interface ppci_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_x;
  logic [5:0] out_y;
  logic [7:0] colour_index;

  modport source (output valid, output out_x, output out_y, output colour_index,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input colour_index,
                  output ready);
endinterface

/* hdl/plasma_pixel_colour_index.sv */
// ----------------------------------------------------------------------------
// plasma_pixel_colour_index
// four radial sine layers averaged into a plasma palette position
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while no result is held, set by the fully pipelined square roots
//   (one root bit per stage) and sine units
// a held result freezes the whole pipeline, input ready follows output space
// reset (synchronous) clears only the stage valid bits, data regs keep junk
`timescale 1ns / 1ps

module plasma_pixel_colour_index (
  input  logic            clk,
  input  logic            rst,
  ppci_in_if.sink         pix_in,
  ppci_out_if.source      pix_out
);
  import ppci_pkg::*;

  // input reg, offset/abs stage, square stage, roots, sines, sum, output
  localparam int DEPTH = 3 + SQRT_LAT + SINE_LAT + 2;
  localparam int LAYERS = 4;

  // layer centers
  localparam logic [16:0] L1_CX = 17'd64;
  localparam logic [6:0]  L1_CY = 7'd64;
  localparam logic [6:0]  L2_CX = 7'd32;
  localparam logic [5:0]  L2_CY = 6'd32;
  localparam logic [6:0]  L34_CX = 7'd96;
  localparam logic [13:0] L3_CY = 14'd32;
  localparam logic [5:0]  L4_CY = 6'd50;

  // ceil(2^19 / 7), exact floor(t/7) for any 16-bit t
  localparam logic [32:0] DIV7_MUL = 33'd74899;

  logic              en;
  logic [DEPTH-1:0]  vld;
  logic [6:0]        x_pipe [DEPTH];
  logic [5:0]        y_pipe [DEPTH];

  // stage 0
  logic [15:0] t0;
  // stage 1: offsets from the centers
  logic [16:0] ax;
  logic [32:0] tq_full;
  logic [16:0] ux1;
  logic [6:0]  uy1;
  logic [6:0]  ux2;
  logic [5:0]  uy2;
  logic [6:0]  ux34;
  logic [5:0]  uy4;
  logic [13:0] tq;
  // stage 2: squared distances
  logic [13:0]      ay3;
  logic [13:0]      uy3;
  logic [D2_W-1:0]  d2 [LAYERS];
  // roots and sines
  logic [DIST_W-1:0]        radius [LAYERS];
  logic signed [SINE_W-1:0] sine [LAYERS];
  logic [PMUL_W-1:0]        pmul [LAYERS];
  // sum and index
  logic signed [18:0] sum_q;
  logic [18:0]        biased;
  logic [7:0]         idx_q;

  // one enable for every stage: move unless the result is held
  assign en = !vld[DEPTH-1] || pix_out.ready;
  assign pix_in.ready = en;

  // valid bits and echoed coordinates ride along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], pix_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_pipe[0] <= pix_in.pixel_x;
      y_pipe[0] <= pix_in.pixel_y;
      t0        <= pix_in.frame_time;
      for (int i = 1; i < DEPTH; i++) begin
        x_pipe[i] <= x_pipe[i-1];
        y_pipe[i] <= y_pipe[i-1];
      end
    end
  end

  // stage 1: shifted coordinates, absolute offsets, t / 7 by reciprocal
  assign ax      = 17'(x_pipe[0]) + 17'(t0);
  assign tq_full = 33'(t0) * DIV7_MUL;

  always_ff @(posedge clk) begin
    if (en) begin
      ux1  <= (ax >= L1_CX) ? ax - L1_CX : L1_CX - ax;
      uy1  <= L1_CY - 7'(y_pipe[0]);
      ux2  <= (x_pipe[0] >= L2_CX) ? x_pipe[0] - L2_CX : L2_CX - x_pipe[0];
      uy2  <= (y_pipe[0] >= L2_CY) ? y_pipe[0] - L2_CY : L2_CY - y_pipe[0];
      ux34 <= (x_pipe[0] >= L34_CX) ? x_pipe[0] - L34_CX : L34_CX - x_pipe[0];
      uy4  <= (y_pipe[0] >= L4_CY) ? y_pipe[0] - L4_CY : L4_CY - y_pipe[0];
      tq   <= tq_full[32:19];
    end
  end

  // stage 2: layer three moves down with time, then all squares
  assign ay3 = 14'(y_pipe[1]) + tq;
  assign uy3 = (ay3 >= L3_CY) ? ay3 - L3_CY : L3_CY - ay3;

  always_ff @(posedge clk) begin
    if (en) begin
      d2[0] <= D2_W'(ux1) * D2_W'(ux1) + D2_W'(uy1) * D2_W'(uy1);
      d2[1] <= D2_W'(ux2) * D2_W'(ux2) + D2_W'(uy2) * D2_W'(uy2);
      d2[2] <= D2_W'(ux34) * D2_W'(ux34) + D2_W'(uy3) * D2_W'(uy3);
      d2[3] <= D2_W'(ux34) * D2_W'(ux34) + D2_W'(uy4) * D2_W'(uy4);
    end
  end

  // layer three has divisor 3.5, the rest 4
  assign pmul[0] = PHASE_MUL_DIV4;
  assign pmul[1] = PHASE_MUL_DIV4;
  assign pmul[2] = PHASE_MUL_DIV3P5;
  assign pmul[3] = PHASE_MUL_DIV4;

  // per layer: distance with 8 fraction bits is sqrt(d2 << 16), then sine
  for (genvar l = 0; l < LAYERS; l++) begin : g_layer
    ppci_isqrt #(
      .W (SQRT_W)
    ) u_isqrt (
      .clk      (clk),
      .en       (en),
      .radicand ({{(SQRT_W - D2_W - 16){1'b0}}, d2[l], 16'h0000}),
      .root     (radius[l])
    );

    ppci_sine u_sine (
      .clk       (clk),
      .en        (en),
      .radius    (radius[l]),
      .phase_mul (pmul[l]),
      .sine      (sine[l])
    );
  end

  // sum of four Q1.15 sines
  always_ff @(posedge clk) begin
    if (en) begin
      sum_q <= 19'(sine[0]) + 19'(sine[1]) + 19'(sine[2]) + 19'(sine[3]);
    end
  end

  // floor((avg + 1) * 128); only the all-peaks case reaches 256
  assign biased = $unsigned(sum_q) + 19'd131072;

  always_ff @(posedge clk) begin
    if (en) begin
      idx_q <= biased[18] ? 8'hFF : biased[17:10];
    end
  end

  assign pix_out.valid        = vld[DEPTH-1];
  assign pix_out.out_x        = x_pipe[DEPTH-1];
  assign pix_out.out_y        = y_pipe[DEPTH-1];
  assign pix_out.colour_index = idx_q;

endmodule

/* hdl/ppci_isqrt.sv */
// ----------------------------------------------------------------------------
// ppci_isqrt
// pipelined integer square root, one result bit per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppci_isqrt #(
  parameter int W = 50
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     radicand,
  output logic [W/2-1:0]   root
);

  localparam int N = W / 2;

  logic [W-1:0] rem_q  [N];
  logic [W-1:0] root_q [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
    logic [W-1:0] rem_in;
    logic [W-1:0] root_in;
    logic [W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = radicand;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign trial = root_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= (root_in >> 1) + BIT;
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in >> 1;
        end
      end
    end
  end

  assign root = root_q[N-1][N-1:0];

endmodule

/* hdl/ppci_sine.sv */
// ----------------------------------------------------------------------------
// ppci_sine
// distance to turn fraction, then interpolated quarter-wave sine, 6 stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppci_sine (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [ppci_pkg::DIST_W-1:0]          radius,
  input  logic [ppci_pkg::PMUL_W-1:0]          phase_mul,
  output logic signed [ppci_pkg::SINE_W-1:0]   sine
);
  import ppci_pkg::*;

  localparam int HALF_W = PMUL_W / 2;
  localparam int PP_W   = DIST_W + HALF_W;

  // stage 0: split multiply
  logic [PP_W-1:0] p_lo;
  logic [PP_W-1:0] p_hi;
  // stage 1: phase as a fraction of one turn
  logic [47:0] sum48;
  logic [31:0] phase;
  // stage 2: folded quarter position
  logic [30:0] fold_pos;
  logic [30:0] pos;
  logic        neg2;
  // stage 3: table read
  logic [4:0]  lo_idx;
  logic [4:0]  hi_idx;
  logic [15:0] a3;
  logic [11:0] d3;
  logic [15:0] f3;
  logic        sat3;
  logic        neg3;
  // stage 4: interpolation product
  logic [27:0] prod_full;
  logic [11:0] prod4;
  logic [15:0] a4;
  logic        sat4;
  logic        neg4;
  // stage 5: magnitude and sign
  logic [15:0] mag;

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo <= PP_W'(radius) * PP_W'(phase_mul[HALF_W-1:0]);
      p_hi <= PP_W'(radius) * PP_W'(phase_mul[PMUL_W-1:HALF_W]);
    end
  end

  assign sum48 = {p_hi[47-HALF_W:0], {HALF_W{1'b0}}} + 48'(p_lo);

  always_ff @(posedge clk) begin
    if (en) begin
      phase <= sum48[47:16];
    end
  end

  // odd quadrants run the table backwards
  assign fold_pos = phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]})
                              : {1'b0, phase[29:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      pos  <= fold_pos;
      neg2 <= phase[31];
    end
  end

  assign lo_idx = {1'b0, pos[29:26]};
  assign hi_idx = lo_idx + 5'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      a3   <= QSINE[lo_idx];
      d3   <= 12'(QSINE[hi_idx] - QSINE[lo_idx]);
      f3   <= pos[25:10];
      sat3 <= pos[30];
      neg3 <= neg2;
    end
  end

  assign prod_full = 28'(d3) * 28'(f3);

  always_ff @(posedge clk) begin
    if (en) begin
      prod4 <= prod_full[27:16];
      a4    <= a3;
      sat4  <= sat3;
      neg4  <= neg3;
    end
  end

  // peak of the wave at exactly a quarter turn
  assign mag = sat4 ? QSINE[16] : (a4 + 16'(prod4));

  always_ff @(posedge clk) begin
    if (en) begin
      sine <= neg4 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

/* hdl/ppci_checker.sv */
// ----------------------------------------------------------------------------
// ppci_checker
// port-level checks on the plasma colour index pipeline, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppci_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_x,
  input logic [5:0] out_y,
  input logic [7:0] colour_index
);

  // a held result stays put
  `PPCI_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(colour_index))

  // input side takes a transfer exactly when the output side has room
  `PPCI_ASSERT(a_ready_link, clk, rst, in_ready == (!out_valid || out_ready))

  // reset empties the pipeline
  `PPCI_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind plasma_pixel_colour_index ppci_checker u_ppci_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (pix_in.ready),
  .out_valid    (pix_out.valid),
  .out_ready    (pix_out.ready),
  .out_x        (pix_out.out_x),
  .out_y        (pix_out.out_y),
  .colour_index (pix_out.colour_index)
);

/* sim/tb_plasma_pixel_colour_index.sv */
// ----------------------------------------------------------------------------
// tb_plasma_pixel_colour_index
// self-checking bench: pixels stream in with bursty gaps, results drain under
// a stall pattern, and a scoreboard predicts every colour index
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_plasma_pixel_colour_index;
  import ppci_pkg::*;

  localparam int RANDOM_PIXELS  = 450;
  localparam int IDLE_LIMIT     = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic [6:0]  x;
    logic [5:0]  y;
    logic [15:0] t;
  } pixel_req_t;

  typedef struct {
    logic [6:0] x;
    logic [5:0] y;
    logic [7:0] colour;
  } pixel_res_t;

  // predicts each colour index from the accepted pixel and checks results in order
  class colour_index_scoreboard;
    pixel_res_t pending_q[$];
    int         mismatches;
    int         checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // distance with 8 fraction bits
    function longint unsigned radial_dist(longint ax, longint ay, longint cx, longint cy);
      longint          dx;
      longint          dy;
      longint unsigned ux;
      longint unsigned uy;
      dx = ax - cx;
      dy = ay - cy;
      ux = (dx < 0) ? -dx : dx;
      uy = (dy < 0) ? -dy : dy;
      return int_root((ux * ux + uy * uy) << 16);
    endfunction

    function int layer_sine(longint unsigned dq8, longint unsigned mul);
      longint unsigned prod;
      bit [31:0]       phase;
      bit [31:0]       pos;
      bit [31:0]       idx;
      bit [31:0]       frac;
      bit [31:0]       lo;
      bit [31:0]       hi;
      int              mag;
      prod  = (dq8 * mul) >> 16;
      phase = prod[31:0];
      pos   = {2'b00, phase[29:0]};
      if (phase[30]) pos = 32'h4000_0000 - pos;
      idx = pos >> 26;
      if (idx >= 16) begin
        mag = int'(QSINE[16]);
      end else begin
        frac = (pos >> 10) & 32'h0000_FFFF;
        lo   = 32'(QSINE[idx]);
        hi   = 32'(QSINE[idx + 1]);
        mag  = int'(lo + (((hi - lo) * frac) >> 16));
      end
      return phase[31] ? -mag : mag;
    endfunction

    function logic [7:0] colour_of(pixel_req_t p);
      longint x;
      longint y;
      longint t;
      int     sum;
      int     idx;
      x = p.x;
      y = p.y;
      t = p.t;
      sum = layer_sine(radial_dist(x + t, y, 64, 64), PHASE_MUL_DIV4)
          + layer_sine(radial_dist(x, y, 32, 32), PHASE_MUL_DIV4)
          + layer_sine(radial_dist(x, y + t / 7, 96, 32), PHASE_MUL_DIV3P5)
          + layer_sine(radial_dist(x, y, 96, 50), PHASE_MUL_DIV4);
      idx = (sum + 131072) >>> 10;
      if (idx > 255) idx = 255;
      if (idx < 0) idx = 0;
      return idx[7:0];
    endfunction

    function void note_pixel(pixel_req_t p);
      pixel_res_t r;
      r.x      = p.x;
      r.y      = p.y;
      r.colour = colour_of(p);
      pending_q.push_back(r);
    endfunction

    function void check_result(pixel_res_t got);
      pixel_res_t want;
      int         diff;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: x=%0d y=%0d colour_index=%0d",
               got.x, got.y, got.colour);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.x !== want.x) begin
        $error("out_x mismatch: expected %0d actual %0d", want.x, got.x);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $error("out_y mismatch: expected %0d actual %0d", want.y, got.y);
        mismatches++;
      end
      // an index off by one is within the allowed rounding error
      diff = int'(got.colour) - int'(want.colour);
      if ($isunknown(got.colour) || diff > 1 || diff < -1) begin
        $error("colour_index mismatch: expected %0d actual %0d", want.colour, got.colour);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ppci_in_if  pix_in_ch ();
  ppci_out_if pix_out_ch ();

  plasma_pixel_colour_index u_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in_ch.sink),
    .pix_out (pix_out_ch.source)
  );

  colour_index_scoreboard sb = new();
  pixel_req_t             stim_q[$];
  int                     sent_count;
  int                     idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // directed pixels: field extremes, layer centers, frame wrap, t/7 steps
  task automatic add_pixel(int x, int y, int t);
    pixel_req_t p;
    p.x = 7'(x);
    p.y = 6'(y);
    p.t = 16'(t);
    stim_q.push_back(p);
  endtask

  task automatic build_stimulus();
    int x0;
    int y0;
    int t0;
    int run_len;
    add_pixel(0, 0, 0);
    add_pixel(127, 63, 65535);
    add_pixel(127, 0, 0);
    add_pixel(0, 63, 65535);
    add_pixel(64, 63, 0);
    add_pixel(32, 32, 0);
    add_pixel(96, 32, 0);
    add_pixel(96, 50, 0);
    add_pixel(96, 32, 6);
    add_pixel(96, 32, 7);
    add_pixel(0, 0, 65534);
    add_pixel(0, 0, 65535);
    add_pixel(0, 0, 0);
    add_pixel(127, 63, 32768);
    add_pixel(85, 42, 21845);
    add_pixel(42, 21, 43690);
    add_pixel(1, 1, 1);
    add_pixel(126, 62, 65533);
    // random part: mostly short scan runs along a row within one frame,
    // the rest are scattered pixels anywhere in the field ranges
    while (stim_q.size() < 18 + RANDOM_PIXELS) begin
      t0 = $urandom_range(0, 65535);
      if ($urandom_range(0, 3) == 0) begin
        add_pixel($urandom_range(0, 127), $urandom_range(0, 63), t0);
      end else begin
        x0      = $urandom_range(0, 127);
        y0      = $urandom_range(0, 63);
        run_len = $urandom_range(1, 16);
        for (int k = 0; k < run_len; k++) add_pixel((x0 + k) % 128, y0, t0);
      end
    end
  endtask

  // sender: bursts of random length separated by random gaps
  task automatic drive_pixels();
    bit offering;
    int burst_left;
    int gap_left;
    offering   = 0;
    burst_left = $urandom_range(1, 20);
    gap_left   = 0;
    while (sent_count < stim_q.size()) begin
      @(posedge clk);
      if (pix_in_ch.valid && pix_in_ch.ready) begin
        sent_count++;
        offering = 0;
      end
      if (!offering && sent_count < stim_q.size()) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_in_ch.valid <= 1'b0;
        end else begin
          pix_in_ch.valid      <= 1'b1;
          pix_in_ch.pixel_x    <= stim_q[sent_count].x;
          pix_in_ch.pixel_y    <= stim_q[sent_count].y;
          pix_in_ch.frame_time <= stim_q[sent_count].t;
          offering = 1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end else if (!offering) begin
        pix_in_ch.valid <= 1'b0;
      end
    end
  endtask

  // receiver: stretches of always-ready, coin-flip and mostly-stalled,
  // plus one long hold-off so the pipeline fills and input ready drops
  initial begin
    bit hold_done;
    int mode;
    int stretch;
    hold_done = 0;
    pix_out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (!hold_done && sent_count >= 60) begin
        pix_out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done = 1;
      end
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(1, 40);
      repeat (stretch) begin
        @(posedge clk);
        case (mode)
          0: begin
            pix_out_ch.ready <= 1'b1;
          end
          1: begin
            pix_out_ch.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            pix_out_ch.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // transfer monitors, sampled at the edge before any update lands
  always @(posedge clk) begin
    pixel_req_t p;
    pixel_res_t r;
    if (!rst) begin
      if (pix_in_ch.valid && pix_in_ch.ready) begin
        p.x = pix_in_ch.pixel_x;
        p.y = pix_in_ch.pixel_y;
        p.t = pix_in_ch.frame_time;
        sb.note_pixel(p);
      end
      if (pix_out_ch.valid && pix_out_ch.ready) begin
        r.x      = pix_out_ch.out_x;
        r.y      = pix_out_ch.out_y;
        r.colour = pix_out_ch.colour_index;
        sb.check_result(r);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (pix_in_ch.valid && pix_in_ch.ready) ||
        (pix_out_ch.valid && pix_out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst                  <= 1'b1;
    sent_count           = 0;
    idle_cycles          = 0;
    pix_in_ch.valid      <= 1'b0;
    pix_in_ch.pixel_x    <= '0;
    pix_in_ch.pixel_y    <= '0;
    pix_in_ch.frame_time <= '0;
    build_stimulus();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    drive_pixels();
    @(posedge clk);
    pix_in_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    // let any stray extra result show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d pixels (field extremes, layer centers, frame wrap, scan runs)",
             stim_q.size());
    $display("%0d results checked under bursty input and stalled output, %0d mismatches",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
